/* hw/rtl/tpt_pkg.sv */
package tpt_pkg;

	// Table geometry
	localparam int NUM_TIMERS = 32;
	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	// Request queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [15:0] TICK_STEP_RST = 16'd10;

	typedef enum logic [1:0] {
		OP_SCHED  = 2'd0,
		OP_TICK   = 2'd1,
		OP_CANCEL = 2'd2,
		OP_BIND   = 2'd3
	} op_t;

	// Class given to each word by the front
	typedef enum logic [2:0] {
		CL_SCHED,
		CL_TICK,
		CL_CANCEL,
		CL_BIND,
		CL_BAD
	} cls_t;

	typedef enum logic [3:0] {
		EV_ACCEPTED      = 4'd0,
		EV_FULL          = 4'd1,
		EV_BAD_ID        = 4'd2,
		EV_CANCELLED     = 4'd3,
		EV_PLACE         = 4'd4,
		EV_PLACE_TRACKED = 4'd5,
		EV_KILL          = 4'd6,
		EV_IDLE          = 4'd7,
		EV_BOUND         = 4'd8
	} ev_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_FINAL
	} bst_t;

	// Classified request as held in the queue
	typedef struct packed {
		cls_t               cls;
		logic [15:0]        tmpl;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [16:0]        delay;
		logic [15:0]        destroy;
		logic [31:0]        owner;
		logic               epi;
		logic [31:0]        target;
		logic [IDX_W-1:0]   slot;
	} req_t;

	// Placement data of one slot
	typedef struct packed {
		logic [15:0]        tmpl;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} slot_a_t;

	// Counters and owner data of one slot
	typedef struct packed {
		logic [16:0] fire;
		logic [15:0] destroy;
		logic [31:0] owner;
		logic        epi;
	} slot_b_t;

	localparam int A_W = $bits(slot_a_t);
	localparam int B_W = $bits(slot_b_t);
	localparam int C_W = 32;

	typedef struct packed {
		ev_t                ev;
		logic [4:0]         slot;
		logic [15:0]        tmpl;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [31:0]        owner;
		logic               epi;
		logic [31:0]        thing;
	} res_t;

	function automatic res_t mk_res(input ev_t ev, input logic [4:0] s);
		res_t r;
		r = '0;
		r.ev = ev;
		r.slot = s;
		return r;
	endfunction

	// Low five bits of a slot index
	function automatic logic [4:0] to_slot(input logic [IDX_W-1:0] i);
		logic [IDX_W+4:0] t;
		t = {5'b0, i};
		return t[4:0];
	endfunction

	function automatic logic [IDX_W-1:0] to_idx(input logic [4:0] s);
		logic [IDX_W+4:0] t;
		t = {{IDX_W{1'b0}}, s};
		return t[IDX_W-1:0];
	endfunction

	function automatic logic [16:0] sat_sub17(input logic [16:0] v, input logic [15:0] s);
		return (v > {1'b0, s}) ? (v - {1'b0, s}) : 17'd0;
	endfunction

	function automatic logic [15:0] sat_sub16(input logic [15:0] v, input logic [15:0] s);
		return (v > s) ? (v - s) : 16'd0;
	endfunction

endpackage

/* hw/rtl/tpt_in_if.sv */
interface tpt_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [15:0]        template_id;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [15:0]        fire_ms;
	logic [15:0]        jitter_ms;
	logic [15:0]        destroy_ms;
	logic [31:0]        owner_tag;
	logic               epicenter;
	logic [31:0]        target_id;
	logic [4:0]         slot_index;

	modport source (
		output valid, opcode, template_id, pos_x, pos_y, fire_ms, jitter_ms,
		       destroy_ms, owner_tag, epicenter, target_id, slot_index,
		input  ready
	);

	modport sink (
		input  valid, opcode, template_id, pos_x, pos_y, fire_ms, jitter_ms,
		       destroy_ms, owner_tag, epicenter, target_id, slot_index,
		output ready
	);
endinterface

/* hw/rtl/tpt_out_if.sv */
interface tpt_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         event_res;
	logic [4:0]         slot;
	logic [15:0]        out_template;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic [31:0]        out_owner;
	logic               out_epicenter;
	logic [31:0]        out_thing;
	logic               last;

	modport source (
		output valid, event_res, slot, out_template, out_x, out_y, out_owner,
		       out_epicenter, out_thing, last,
		input  ready
	);

	modport sink (
		input  valid, event_res, slot, out_template, out_x, out_y, out_owner,
		       out_epicenter, out_thing, last,
		output ready
	);
endinterface

/* hw/rtl/two_phase_timer_table_core.sv */
// Bind and rejected words give their one result through the held-result and output registers;
// tick, cancel and schedule walk the slots one per cycle, unless a held-off output stalls a
// tick or cancel walk, and present their final word once the walk ends.
// The back takes a new word only once the last one has delivered its final word; the slot RAMs
// each have a single read port, and a two-word queue lets the input side run ahead of the walk.
// Reset: arst_n clears the per-slot valid bits at once (no clearing pass); tick_step goes to 10.
module two_phase_timer_table_core (
	input  logic        clk,
	input  logic        arst_n,
	tpt_in_if.sink      in_ch,
	tpt_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import tpt_pkg::*;

	logic q_valid;
	logic q_pop;
	req_t q_req;

	// Accept, classify and queue
	tpt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_pop   (q_pop),
		.q_valid (q_valid),
		.q_req   (q_req)
	);

	// Walk the slot table and deliver results
	tpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop),
		.out_ch    (out_ch)
	);
endmodule

/* hw/rtl/tpt_ram.sv */
module tpt_ram #(
	parameter int W = 32,
	parameter int D = 32
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                         wdata,
	input  logic                                 re,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                         rdata
);
	logic [W-1:0] mem [D];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* hw/rtl/tpt_front.sv */
module tpt_front (
	input  logic          clk,
	input  logic          arst_n,
	tpt_in_if.sink        in_ch,
	input  logic          q_pop,
	output logic          q_valid,
	output tpt_pkg::req_t q_req
);
	import tpt_pkg::*;

	req_t              cls_req;
	req_t              q_mem [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	// Classify the incoming word and sum the placement delay
	always_comb begin
		cls_req.tmpl    = in_ch.template_id;
		cls_req.x       = in_ch.pos_x;
		cls_req.y       = in_ch.pos_y;
		cls_req.delay   = {1'b0, in_ch.fire_ms} + {1'b0, in_ch.jitter_ms};
		cls_req.destroy = in_ch.destroy_ms;
		cls_req.owner   = in_ch.owner_tag;
		cls_req.epi     = in_ch.epicenter;
		cls_req.target  = in_ch.target_id;
		cls_req.slot    = to_idx(in_ch.slot_index);
		case (op_t'(in_ch.opcode))
			OP_SCHED: begin
				cls_req.cls = CL_SCHED;
			end
			OP_TICK: begin
				cls_req.cls = CL_TICK;
			end
			OP_CANCEL: begin
				cls_req.cls = (in_ch.target_id == 32'd0) ? CL_BAD : CL_CANCEL;
			end
			OP_BIND: begin
				cls_req.cls = (int'(in_ch.slot_index) < NUM_TIMERS) ? CL_BIND : CL_BAD;
			end
			default: begin
				cls_req.cls = CL_BAD;
			end
		endcase
	end

	assign in_ch.ready = (cnt_q != QCNT_W'(QDEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign pop = q_pop && (cnt_q != '0);
	assign q_valid = (cnt_q != '0);
	assign q_req = q_mem[rptr_q];

	// Advance queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	// Hold queued words
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wptr_q] <= cls_req;
		end
	end
endmodule

/* hw/rtl/tpt_back.sv */
module tpt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	input  logic          q_valid,
	input  tpt_pkg::req_t q_req,
	output logic          q_pop,
	tpt_out_if.source     out_ch
);
	import tpt_pkg::*;

	bst_t             st_q;
	bst_t             nx;
	logic [IDX_W-1:0] sidx_q;
	logic [IDX_W-1:0] sidx_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic [15:0]      step_q;
	req_t             cur_q;
	res_t             pend_q;
	res_t             pend_d;
	logic             pend_v_q;
	logic             pend_v_d;
	res_t             out_q;
	res_t             out_d;
	logic             out_last_q;
	logic             out_last_d;
	logic             ov_q;
	logic             out_ld;
	logic             out_free;

	logic [NUM_TIMERS-1:0] vmain_q;
	logic [NUM_TIMERS-1:0] vthing_q;
	logic [IDX_W-1:0]      v_idx;
	logic                  vm_set;
	logic                  vm_clr;
	logic                  vt_set;
	logic                  vt_clr;

	// Slot RAM ports
	logic             re;
	logic [IDX_W-1:0] raddr;
	logic [IDX_W-1:0] waddr;
	logic             we_a;
	logic             we_b;
	logic             we_c;
	slot_a_t          a_wr;
	slot_b_t          b_wr;
	logic [C_W-1:0]   c_wr;
	logic [A_W-1:0]   rd_a;
	logic [B_W-1:0]   rd_b;
	logic [C_W-1:0]   rd_c;

	// Evaluation of the slot under scan
	slot_a_t     a_rd;
	slot_b_t     b_rd;
	logic [31:0] thing;
	logic        busy;
	logic        match;
	logic [16:0] nf;
	logic [15:0] nd;
	logic        ev_hit;
	res_t        ev_d;
	logic        take;
	logic        stall;
	logic        last_slot;

	tpt_ram #(.W(A_W), .D(NUM_TIMERS)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (a_wr),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_a)
	);

	tpt_ram #(.W(B_W), .D(NUM_TIMERS)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (b_wr),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_b)
	);

	tpt_ram #(.W(C_W), .D(NUM_TIMERS)) u_ram_c (
		.clk   (clk),
		.we    (we_c),
		.waddr (waddr),
		.wdata (c_wr),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_c)
	);

	// Mask counter and bound-id entries that are not valid to zero and work out the slot's event
	always_comb begin
		a_rd = slot_a_t'(rd_a);
		b_rd = vmain_q[sidx_q] ? slot_b_t'(rd_b) : '0;
		thing = vthing_q[sidx_q] ? rd_c : 32'd0;
		busy = (b_rd.fire != 17'd0) || (b_rd.destroy != 16'd0);
		match = (thing == cur_q.target) || (b_rd.owner == cur_q.target);
		nf = sat_sub17(b_rd.fire, step_q);
		nd = sat_sub16(b_rd.destroy, step_q);
		ev_hit = 1'b0;
		ev_d = mk_res(EV_IDLE, 5'd0);
		case (cur_q.cls)
			CL_TICK: begin
				if (b_rd.fire != 17'd0) begin
					if (nf == 17'd0) begin
						ev_hit = 1'b1;
						ev_d = mk_res((b_rd.destroy != 16'd0) ? EV_PLACE_TRACKED : EV_PLACE,
							to_slot(sidx_q));
						ev_d.tmpl = a_rd.tmpl;
						ev_d.x = a_rd.x;
						ev_d.y = a_rd.y;
						ev_d.owner = b_rd.owner;
						ev_d.epi = b_rd.epi;
					end
				end else if ((b_rd.destroy != 16'd0) && (nd == 16'd0)) begin
					ev_hit = 1'b1;
					ev_d = mk_res(EV_KILL, to_slot(sidx_q));
					ev_d.thing = thing;
				end
			end
			CL_CANCEL: begin
				if (match && busy) begin
					ev_hit = 1'b1;
					ev_d = mk_res(EV_CANCELLED, to_slot(sidx_q));
				end
			end
			default: begin
				ev_hit = 1'b0;
			end
		endcase
	end

	assign last_slot = (sidx_q == IDX_W'(NUM_TIMERS - 1));
	assign out_free = !ov_q || out_ch.ready;
	assign take = ev_hit && (cnt_q < CNT_W'(MAX_RESULTS));
	assign stall = take && pend_v_q && !out_free;

	// Sequence one request: pop, walk the slots (schedule, tick, cancel), deliver the final word
	always_comb begin
		nx = st_q;
		q_pop = 1'b0;
		re = 1'b0;
		raddr = sidx_q;
		waddr = sidx_q;
		sidx_d = sidx_q;
		cnt_d = cnt_q;
		we_a = 1'b0;
		we_b = 1'b0;
		we_c = 1'b0;
		a_wr.tmpl = cur_q.tmpl;
		a_wr.x = cur_q.x;
		a_wr.y = cur_q.y;
		b_wr = b_rd;
		c_wr = q_req.target;
		v_idx = sidx_q;
		vm_set = 1'b0;
		vm_clr = 1'b0;
		vt_set = 1'b0;
		vt_clr = 1'b0;
		pend_d = pend_q;
		pend_v_d = pend_v_q;
		out_ld = 1'b0;
		out_d = pend_q;
		out_last_d = 1'b0;
		case (st_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_req.cls)
						CL_BIND: begin
							we_c = 1'b1;
							waddr = q_req.slot;
							v_idx = q_req.slot;
							vt_set = 1'b1;
							pend_d = mk_res(EV_BOUND, to_slot(q_req.slot));
							pend_v_d = 1'b1;
							nx = B_FINAL;
						end
						CL_BAD: begin
							pend_d = mk_res(EV_BAD_ID, 5'd0);
							pend_v_d = 1'b1;
							nx = B_FINAL;
						end
						default: begin
							re = 1'b1;
							raddr = '0;
							sidx_d = '0;
							cnt_d = '0;
							nx = B_SCAN;
						end
					endcase
				end
			end
			B_SCAN: begin
				if (cur_q.cls == CL_SCHED) begin
					// Take the first free slot
					if (!busy) begin
						we_a = 1'b1;
						we_b = 1'b1;
						b_wr.fire = cur_q.delay;
						b_wr.destroy = cur_q.destroy;
						b_wr.owner = cur_q.owner;
						b_wr.epi = cur_q.epi;
						vm_set = 1'b1;
						vt_clr = 1'b1;
						pend_d = mk_res(EV_ACCEPTED, to_slot(sidx_q));
						pend_v_d = 1'b1;
						nx = B_FINAL;
					end else if (last_slot) begin
						pend_d = mk_res(EV_FULL, 5'd0);
						pend_v_d = 1'b1;
						nx = B_FINAL;
					end else begin
						re = 1'b1;
						raddr = sidx_q + IDX_W'(1);
						sidx_d = sidx_q + IDX_W'(1);
					end
				end else if (!stall) begin
					// Update the slot
					if (cur_q.cls == CL_TICK) begin
						if (b_rd.fire != 17'd0) begin
							we_b = 1'b1;
							b_wr.fire = nf;
						end else if (b_rd.destroy != 16'd0) begin
							we_b = 1'b1;
							b_wr.destroy = nd;
							vt_clr = (nd == 16'd0);
						end
					end else if (match) begin
						vm_clr = 1'b1;
						vt_clr = 1'b1;
					end
					// Hold the newest event back so the final one can carry last
					if (take) begin
						if (pend_v_q) begin
							out_ld = 1'b1;
							out_d = pend_q;
							out_last_d = 1'b0;
						end
						pend_d = ev_d;
						pend_v_d = 1'b1;
						cnt_d = cnt_q + CNT_W'(1);
					end
					if (last_slot) begin
						if (!(pend_v_q || take)) begin
							pend_d = mk_res(EV_IDLE, 5'd0);
							pend_v_d = 1'b1;
						end
						nx = B_FINAL;
					end else begin
						re = 1'b1;
						raddr = sidx_q + IDX_W'(1);
						sidx_d = sidx_q + IDX_W'(1);
					end
				end
			end
			B_FINAL: begin
				if (out_free) begin
					out_ld = 1'b1;
					out_d = pend_q;
					out_last_d = 1'b1;
					pend_v_d = 1'b0;
					nx = B_IDLE;
				end
			end
			default: begin
				nx = B_IDLE;
			end
		endcase
	end

	// Control registers, valid bits and tick step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			sidx_q <= '0;
			cnt_q <= '0;
			pend_v_q <= 1'b0;
			ov_q <= 1'b0;
			step_q <= TICK_STEP_RST;
			vmain_q <= '0;
			vthing_q <= '0;
		end else begin
			st_q <= nx;
			sidx_q <= sidx_d;
			cnt_q <= cnt_d;
			pend_v_q <= pend_v_d;
			if (out_ld) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			if (cfg_we) begin
				step_q <= cfg_wdata;
			end
			if (vm_set) begin
				vmain_q[v_idx] <= 1'b1;
			end else if (vm_clr) begin
				vmain_q[v_idx] <= 1'b0;
			end
			if (vt_set) begin
				vthing_q[v_idx] <= 1'b1;
			end else if (vt_clr) begin
				vthing_q[v_idx] <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (q_pop) begin
			cur_q <= q_req;
		end
		if (out_ld) begin
			out_q <= out_d;
			out_last_q <= out_last_d;
		end
	end

	assign out_ch.valid = ov_q;
	assign out_ch.event_res = out_q.ev;
	assign out_ch.slot = out_q.slot;
	assign out_ch.out_template = out_q.tmpl;
	assign out_ch.out_x = out_q.x;
	assign out_ch.out_y = out_q.y;
	assign out_ch.out_owner = out_q.owner;
	assign out_ch.out_epicenter = out_q.epi;
	assign out_ch.out_thing = out_q.thing;
	assign out_ch.last = out_last_q;

	// A final word always has a held result behind it
	a_final_pend: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_FINAL |-> pend_v_q)
		else $error("final state without a held result");

	// Nothing is left held once a request is finished
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_IDLE |-> !pend_v_q)
		else $error("held result left over in idle");

	// Result count never passes the cap
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("result count above cap");

	// Scan never reads the slot it writes in the same cycle
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(we_b && re) |-> (waddr != raddr))
		else $error("read and write of one slot in one cycle");

	// A stalled slot is kept in place until the output frees up
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_SCAN && stall) |=> (st_q == B_SCAN && $stable(sidx_q)))
		else $error("scan moved on during a stall");
endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
	import tpt_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = NUM_TIMERS + 8;
	localparam int ID_POOL       = 8;

	typedef enum int {
		MIX_NORMAL,
		MIX_FILL
	} mix_t;

	typedef struct {
		op_t                op;
		logic [15:0]        tmpl;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        fire;
		logic [15:0]        jitter;
		logic [15:0]        destroy;
		logic [31:0]        owner;
		logic               epi;
		logic [31:0]        target;
		logic [4:0]         slot_idx;
	} request_t;

	typedef struct {
		ev_t                ev;
		logic [4:0]         slot;
		logic [15:0]        tmpl;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [31:0]        owner;
		logic               epi;
		logic [31:0]        thing;
		logic               last;
	} event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;

	tpt_in_if  in_ch();
	tpt_out_if out_ch();

	two_phase_timer_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Events still owed by the block, oldest first
	event_t pending_events[$];
	int     word_events;
	int     mismatches = 0;
	int     hold_cycles = 0;
	bit     steady_flow = 1'b0;
	int     cycle_count;

	// Predicted slot state and tick step
	logic [16:0] t_fire  [NUM_TIMERS];
	logic [15:0] t_kill  [NUM_TIMERS];
	logic [15:0] t_tmpl  [NUM_TIMERS];
	logic [15:0] t_x     [NUM_TIMERS];
	logic [15:0] t_y     [NUM_TIMERS];
	logic [31:0] t_owner [NUM_TIMERS];
	logic [31:0] t_thing [NUM_TIMERS];
	logic        t_epi   [NUM_TIMERS];
	logic [15:0] step_ms;

	// Queue one predicted event, dropping any beyond the per-word cap
	function automatic void emit_event(input ev_t ev, input int s, input bit with_data,
			input logic [31:0] thing);
		event_t e;
		if (word_events >= MAX_RESULTS)
			return;
		e.ev    = ev;
		e.slot  = s[4:0];
		e.tmpl  = with_data ? t_tmpl[s] : 16'd0;
		e.x     = with_data ? t_x[s] : 16'd0;
		e.y     = with_data ? t_y[s] : 16'd0;
		e.owner = with_data ? t_owner[s] : 32'd0;
		e.epi   = with_data ? t_epi[s] : 1'b0;
		e.thing = thing;
		e.last  = 1'b0;
		pending_events.push_back(e);
		word_events++;
	endfunction

	// Advance the predicted timers by one accepted word and queue its events
	function automatic void step_timers(input request_t r);
		int free_slot;
		bit busy;
		word_events = 0;
		case (r.op)
			OP_SCHED: begin
				free_slot = -1;
				for (int i = NUM_TIMERS - 1; i >= 0; i--)
					if (t_fire[i] == 17'd0 && t_kill[i] == 16'd0)
						free_slot = i;
				if (free_slot < 0) begin
					emit_event(EV_FULL, 0, 1'b0, 32'd0);
				end else begin
					t_fire[free_slot]  = {1'b0, r.fire} + {1'b0, r.jitter};
					t_kill[free_slot]  = r.destroy;
					t_tmpl[free_slot]  = r.tmpl;
					t_x[free_slot]     = r.x;
					t_y[free_slot]     = r.y;
					t_owner[free_slot] = r.owner;
					t_epi[free_slot]   = r.epi;
					t_thing[free_slot] = 32'd0;
					emit_event(EV_ACCEPTED, free_slot, 1'b0, 32'd0);
				end
			end
			OP_TICK: begin
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (t_fire[i] != 17'd0) begin
						t_fire[i] = (t_fire[i] > {1'b0, step_ms}) ?
							t_fire[i] - {1'b0, step_ms} : 17'd0;
						if (t_fire[i] == 17'd0)
							emit_event(t_kill[i] != 16'd0 ? EV_PLACE_TRACKED : EV_PLACE,
								i, 1'b1, 32'd0);
					end else if (t_kill[i] != 16'd0) begin
						t_kill[i] = (t_kill[i] > step_ms) ? t_kill[i] - step_ms : 16'd0;
						if (t_kill[i] == 16'd0) begin
							emit_event(EV_KILL, i, 1'b0, t_thing[i]);
							t_thing[i] = 32'd0;
						end
					end
				end
				if (word_events == 0)
					emit_event(EV_IDLE, 0, 1'b0, 32'd0);
			end
			OP_CANCEL: begin
				if (r.target == 32'd0) begin
					emit_event(EV_BAD_ID, 0, 1'b0, 32'd0);
				end else begin
					for (int i = 0; i < NUM_TIMERS; i++) begin
						if (t_thing[i] == r.target || t_owner[i] == r.target) begin
							busy = t_fire[i] != 17'd0 || t_kill[i] != 16'd0;
							t_fire[i]  = 17'd0;
							t_kill[i]  = 16'd0;
							t_tmpl[i]  = 16'd0;
							t_x[i]     = 16'd0;
							t_y[i]     = 16'd0;
							t_owner[i] = 32'd0;
							t_thing[i] = 32'd0;
							t_epi[i]   = 1'b0;
							if (busy)
								emit_event(EV_CANCELLED, i, 1'b0, 32'd0);
						end
					end
					if (word_events == 0)
						emit_event(EV_IDLE, 0, 1'b0, 32'd0);
				end
			end
			default: begin
				if (int'(r.slot_idx) >= NUM_TIMERS) begin
					emit_event(EV_BAD_ID, 0, 1'b0, 32'd0);
				end else begin
					t_thing[r.slot_idx] = r.target;
					emit_event(EV_BOUND, int'(r.slot_idx), 1'b0, 32'd0);
				end
			end
		endcase
		pending_events[pending_events.size() - 1].last = 1'b1;
	endfunction

	function automatic string fmt_event(input event_t e);
		return $sformatf("ev=%0d slot=%0d tmpl=%h x=%h y=%h owner=%h epi=%b thing=%h last=%b",
			e.ev, e.slot, e.tmpl, e.x, e.y, e.owner, e.epi, e.thing, e.last);
	endfunction

	function automatic void note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("tb: t=%0t %s", $time, msg);
	endfunction

	// Offer one word after a random gap and predict it once accepted
	task automatic send_word(input request_t r);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap != 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.opcode      = r.op;
		in_ch.template_id = r.tmpl;
		in_ch.pos_x       = r.x;
		in_ch.pos_y       = r.y;
		in_ch.fire_ms     = r.fire;
		in_ch.jitter_ms   = r.jitter;
		in_ch.destroy_ms  = r.destroy;
		in_ch.owner_tag   = r.owner;
		in_ch.epicenter   = r.epi;
		in_ch.target_id   = r.target;
		in_ch.slot_index  = r.slot_idx;
		in_ch.valid       = 1'b1;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		step_timers(r);
	endtask

	task automatic send_schedule(input logic [15:0] tmpl, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] fire, input logic [15:0] jitter,
			input logic [15:0] destroy, input logic [31:0] owner, input logic epi);
		request_t r;
		r = '{op: OP_SCHED, tmpl: tmpl, x: x, y: y, fire: fire, jitter: jitter,
			destroy: destroy, owner: owner, epi: epi, target: 32'd0, slot_idx: 5'd0};
		send_word(r);
	endtask

	task automatic send_op(input op_t op, input logic [31:0] target, input logic [4:0] s);
		request_t r;
		r = '{op: op, tmpl: 16'd0, x: 16'd0, y: 16'd0, fire: 16'd0, jitter: 16'd0,
			destroy: 16'd0, owner: 32'd0, epi: 1'b0, target: target, slot_idx: s};
		send_word(r);
	endtask

	// Drop valid, then wait for every owed event and let the walk settle
	task automatic drain_events();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_tick_step(input logic [15:0] v);
		drain_events();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we    = 1'b0;
		step_ms   = v;
	endtask

	function automatic logic [31:0] pick_id();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return $urandom_range(1, ID_POOL);
		else if (pick < 75)
			return 32'd0;
		else
			return $urandom;
	endfunction

	// Mostly short delays so slots fire and free up, a few full-range values; the fill mix keeps fire delays long
	function automatic request_t rand_request(input mix_t mix);
		request_t r;
		logic [31:0] draw;
		int pick;
		pick = $urandom_range(0, 99);
		if (mix == MIX_FILL)
			r.op = pick < 85 ? OP_SCHED : pick < 92 ? OP_TICK : pick < 96 ? OP_CANCEL : OP_BIND;
		else
			r.op = pick < 40 ? OP_SCHED : pick < 75 ? OP_TICK : pick < 87 ? OP_CANCEL : OP_BIND;
		draw   = $urandom;
		r.tmpl = draw[15:0];
		r.x    = draw[31:16];
		draw   = $urandom;
		r.y    = draw[15:0];
		r.epi  = draw[16];
		r.slot_idx = draw[21:17];
		pick = $urandom_range(0, 99);
		if (mix == MIX_FILL)
			r.fire = 16'($urandom_range(200, 65535));
		else if (pick < 10)
			r.fire = 16'($urandom_range(0, 65535));
		else if (pick < 20)
			r.fire = 16'd0;
		else
			r.fire = 16'($urandom_range(1, 40));
		pick = $urandom_range(0, 99);
		r.jitter = pick < 85 ? 16'($urandom_range(0, 15)) : 16'($urandom_range(0, 65535));
		pick = $urandom_range(0, 99);
		if (pick < 40)
			r.destroy = 16'd0;
		else if (pick < 90)
			r.destroy = 16'($urandom_range(1, 60));
		else
			r.destroy = 16'($urandom_range(0, 65535));
		r.owner  = pick_id();
		r.target = pick_id();
		return r;
	endfunction

	task automatic run_random(input mix_t mix, input int count);
		repeat (count) send_word(rand_request(mix));
	endtask

	// Empty request, full-range fields, zero fire delay with a kill, tracked placement
	task automatic test_schedule_forms();
		send_schedule(16'h1234, 16'h0010, 16'h0020, 16'd0, 16'd0, 16'd0, 32'd1, 1'b0);
		send_schedule(16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 1'b1);
		send_schedule(16'h0001, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd15, 32'd5, 1'b0);
		send_schedule(16'h0000, 16'h7FFF, 16'h8000, 16'd10, 16'd5, 16'd0, 32'd0, 1'b0);
		send_schedule(16'hA5A5, 16'h5A5A, 16'hC3C3, 16'd7, 16'd0, 16'd20, 32'd6, 1'b1);
	endtask

	// Bind a busy slot and a free one
	task automatic test_bind_slots();
		send_op(OP_BIND, 32'd1234, 5'd3);
		send_op(OP_BIND, 32'hFFFF_FFFF, 5'd31);
	endtask

	// Placements, kills with and without a bound id, then a quiet tick
	task automatic test_tick_expiry();
		repeat (4) send_op(OP_TICK, 32'd0, 5'd0);
	endtask

	// Zero id, a match on owner and on bound id, no match, bind of an idle slot
	task automatic test_cancel();
		send_op(OP_CANCEL, 32'd0, 5'd0);
		send_op(OP_CANCEL, 32'hFFFF_FFFF, 5'd0);
		send_op(OP_CANCEL, 32'd77, 5'd0);
		send_op(OP_BIND, 32'd0, 5'd0);
	endtask

	// Largest step saturates the 17-bit delay; a zero step freezes the counters
	task automatic test_step_extremes();
		set_tick_step(16'hFFFF);
		send_schedule(16'h0F0F, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 32'd2, 1'b1);
		repeat (2) send_op(OP_TICK, 32'd0, 5'd0);
		set_tick_step(16'd0);
		send_schedule(16'h0002, 16'h0003, 16'h0004, 16'd5, 16'd0, 16'd3, 32'd3, 1'b0);
		send_op(OP_TICK, 32'd0, 5'd0);
	endtask

	task automatic test_random_settings();
		set_tick_step(TICK_STEP_RST);
		run_random(MIX_NORMAL, 60);
		set_tick_step(16'd3);
		steady_flow = 1'b1;
		run_random(MIX_NORMAL, 60);
		set_tick_step(16'd1);
		steady_flow = 1'b0;
		run_random(MIX_FILL, 60);
		set_tick_step(16'hFFFF);
		run_random(MIX_NORMAL, 50);
		set_tick_step(16'd0);
		run_random(MIX_NORMAL, 20);
		set_tick_step(16'($urandom_range(1, 65535)));
		run_random(MIX_NORMAL, 60);
	endtask

	// Hold the result side off while words keep coming, so the input stalls
	task automatic test_backpressure();
		set_tick_step(16'($urandom_range(1, 20)));
		hold_cycles = HOLD_CYCLES;
		run_random(MIX_NORMAL, 40);
	endtask

	// Result side: random stalls, a requested long hold, and the check
	initial begin : result_sink
		int stall;
		int n;
		event_t got;
		event_t want;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				out_ch.ready = 1'b0;
				while (n != 0) begin
					@(negedge clk);
					n--;
				end
			end
			stall = steady_flow ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				out_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			got.ev    = ev_t'(out_ch.event_res);
			got.slot  = out_ch.slot;
			got.tmpl  = out_ch.out_template;
			got.x     = out_ch.out_x;
			got.y     = out_ch.out_y;
			got.owner = out_ch.out_owner;
			got.epi   = out_ch.out_epicenter;
			got.thing = out_ch.out_thing;
			got.last  = out_ch.last;
			if (pending_events.size() == 0) begin
				note_failure({"unexpected word: ", fmt_event(got)});
			end else begin
				want = pending_events.pop_front();
				if (got.ev !== want.ev || got.slot !== want.slot || got.tmpl !== want.tmpl ||
						got.x !== want.x || got.y !== want.y || got.owner !== want.owner ||
						got.epi !== want.epi || got.thing !== want.thing ||
						got.last !== want.last)
					note_failure({"mismatch: expected ", fmt_event(want),
						" got ", fmt_event(got)});
			end
		end
	end

	// Give up on a hung block
	initial begin : watchdog
		for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++)
			@(posedge clk);
		$display("tb: errors");
		$finish;
	end

	initial begin
		in_ch.valid       = 1'b0;
		in_ch.opcode      = OP_SCHED;
		in_ch.template_id = 16'd0;
		in_ch.pos_x       = 16'd0;
		in_ch.pos_y       = 16'd0;
		in_ch.fire_ms     = 16'd0;
		in_ch.jitter_ms   = 16'd0;
		in_ch.destroy_ms  = 16'd0;
		in_ch.owner_tag   = 32'd0;
		in_ch.epicenter   = 1'b0;
		in_ch.target_id   = 32'd0;
		in_ch.slot_index  = 5'd0;
		step_ms = TICK_STEP_RST;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			t_fire[i]  = 17'd0;
			t_kill[i]  = 16'd0;
			t_tmpl[i]  = 16'd0;
			t_x[i]     = 16'd0;
			t_y[i]     = 16'd0;
			t_owner[i] = 32'd0;
			t_thing[i] = 32'd0;
			t_epi[i]   = 1'b0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_schedule_forms();
		test_bind_slots();
		test_tick_expiry();
		test_cancel();
		test_step_extremes();
		test_random_settings();
		test_backpressure();

		drain_events();
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
